/* hw/rtl/playfair_cipher_encrypt_assert.svh */
// Assertion macros for the Playfair encryptor.
`ifndef PLAYFAIR_CIPHER_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_ASSERT_SVH

// ante at one edge requires cons at the next edge
`define PF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// cond must never hold at a clock edge
`define PF_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hw/rtl/pf_pkg.sv */
// Shared types, constants and helper functions for the Playfair encryptor.
package pf_pkg;

    localparam int SqDim = 5;
    localparam int SqCells = 25;
    localparam int Alpha = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    localparam letter_t IdxI = 5'd8;
    localparam letter_t IdxJ = 5'd9;
    localparam letter_t IdxX = 5'd23;

    localparam logic [7:0] AsciiUpA = 8'h41;
    localparam logic [7:0] AsciiUpZ = 8'h5A;
    localparam logic [7:0] AsciiLowA = 8'h61;
    localparam logic [7:0] AsciiLowZ = 8'h7A;
    localparam logic [7:0] CaseOffset = 8'h20;

    localparam logic [Alpha-1:0] LetterOne = {{(Alpha-1){1'b0}}, 1'b1};
    localparam logic [Alpha-1:0] JMask = LetterOne << IdxJ;

    typedef enum logic [1:0] {
        ACT_KEY    = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } action_e;

    typedef struct packed {
        logic    valid;
        letter_t letter;
    } clean_t;

    // digraph handed from the core to the output buffer
    typedef struct packed {
        logic    valid;
        letter_t first;
        letter_t second;
    } pf_pair_t;

    function automatic clean_t clean_letter(logic [7:0] b);
        logic [7:0] u;
        clean_t     r;
        u = (b >= AsciiLowA && b <= AsciiLowZ) ? b - CaseOffset : b;
        r.valid = (u >= AsciiUpA && u <= AsciiUpZ);
        r.letter = 5'(u - AsciiUpA);
        if (r.letter == IdxJ)
        begin
            r.letter = IdxI;
        end
        return r;
    endfunction

    function automatic coord_t cell_row(cell_t c);
        coord_t r;
        if (c >= 5'(4 * SqDim))
        begin
            r = 3'd4;
        end
        else if (c >= 5'(3 * SqDim))
        begin
            r = 3'd3;
        end
        else if (c >= 5'(2 * SqDim))
        begin
            r = 3'd2;
        end
        else if (c >= 5'(SqDim))
        begin
            r = 3'd1;
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic cell_t cell_at(coord_t r, coord_t c);
        return 5'({r, 2'b00}) + 5'(r) + 5'(c);
    endfunction

    function automatic coord_t cell_col(cell_t c);
        return 3'(c - cell_at(cell_row(c), 3'd0));
    endfunction

    function automatic coord_t wrap_inc(coord_t v);
        return (v == 3'(SqDim - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [6:0] to_ascii(letter_t l);
        return 7'(AsciiUpA) + 7'(l);
    endfunction

endpackage

/* hw/rtl/pf_if.sv */
// Valid/ready channel interfaces for plaintext actions and cipher letters.
interface pf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink (input valid, input action, input char_in, output ready);
endinterface

interface pf_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_letter;
    logic       last_of_run;

    modport source (output valid, output cipher_letter, output last_of_run, input ready);
    modport sink (input valid, input cipher_letter, input last_of_run, output ready);
endinterface

/* hw/rtl/pf_ram2r.sv */
// Generic RAM, one write port and two registered read ports.
module pf_ram2r #(
    parameter int Width = 5,
    parameter int Depth = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [Width-1:0]         rdata_a,
    output logic [Width-1:0]         rdata_b
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* hw/rtl/pf_rule.sv */
// Digraph geometry: maps two square cells to their cipher cells.
module pf_rule (
    input  pf_pkg::cell_t pa,
    input  pf_pkg::cell_t pb,
    output pf_pkg::cell_t oa,
    output pf_pkg::cell_t ob
);
    import pf_pkg::*;

    coord_t ra, ca, rb, cb;

    always_comb
    begin
        ra = cell_row(pa);
        ca = cell_col(pa);
        rb = cell_row(pb);
        cb = cell_col(pb);
        priority if (ra == rb)
        begin
            oa = cell_at(ra, wrap_inc(ca));
            ob = cell_at(rb, wrap_inc(cb));
        end
        else if (ca == cb)
        begin
            oa = cell_at(wrap_inc(ra), ca);
            ob = cell_at(wrap_inc(rb), cb);
        end
        else
        begin
            oa = cell_at(ra, cb);
            ob = cell_at(rb, ca);
        end
    end

endmodule

/* hw/rtl/pf_core.sv */
// Control, key-square build and digraph lookup over the two square memories.
module pf_core (
    input  logic             clk,
    input  logic             rst_n,
    pf_in_if.sink            plain,
    output pf_pkg::pf_pair_t pair,
    input  logic             pair_ready
);
    import pf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_SQ
    } state_t;

    state_t           state_reg;
    logic [Alpha-1:0] used_reg;
    cell_t            fill_reg;
    logic             done_reg;
    logic             pend_valid_reg;
    letter_t          pend_reg;
    letter_t          walk_reg;

    action_e          act;
    clean_t           clean;
    logic             take;
    logic             key_take;
    logic             fresh;
    logic             end_take;
    logic             pair_go;
    logic [Alpha-1:0] used_base;
    cell_t            fill_base;
    letter_t          place_idx;
    logic             place_en;
    letter_t          pos_a, pos_b;
    cell_t            pos_da, pos_db;
    cell_t            sq_a, sq_b;
    letter_t          sq_da, sq_db;

    assign act = action_e'(plain.action);
    assign clean = clean_letter(plain.char_in);
    assign plain.ready = (state_reg == ST_IDLE);
    assign take = plain.valid && plain.ready;

    // key placement, shared by key letters and the finish walk
    assign key_take = take && (act == ACT_KEY) && clean.valid;
    assign fresh = key_take && done_reg;
    assign used_base = fresh ? JMask : used_reg;
    assign fill_base = fresh ? '0 : fill_reg;
    assign place_idx = (state_reg == ST_FILL) ? walk_reg : clean.letter;
    assign place_en = (key_take || (state_reg == ST_FILL)) && !used_base[place_idx]
                      && (fill_base < 5'(SqCells));

    assign end_take = take && (act == ACT_END) && done_reg && pend_valid_reg;
    assign pair_go = (take && (act == ACT_TEXT) && clean.valid && done_reg && pend_valid_reg)
                     || end_take;
    assign pos_a = pend_reg;
    assign pos_b = (end_take || (clean.letter == pend_reg)) ? IdxX : clean.letter;

    pf_ram2r #(
        .Width (5),
        .Depth (Alpha)
    ) u_pos_mem (
        .clk     (clk),
        .we      (place_en),
        .waddr   (place_idx),
        .wdata   (fill_base),
        .re      (pair_go),
        .raddr_a (pos_a),
        .raddr_b (pos_b),
        .rdata_a (pos_da),
        .rdata_b (pos_db)
    );

    pf_rule u_rule (
        .pa (pos_da),
        .pb (pos_db),
        .oa (sq_a),
        .ob (sq_b)
    );

    pf_ram2r #(
        .Width (5),
        .Depth (SqCells)
    ) u_sq_mem (
        .clk     (clk),
        .we      (place_en),
        .waddr   (fill_base),
        .wdata   (place_idx),
        .re      (state_reg == ST_POS),
        .raddr_a (sq_a),
        .raddr_b (sq_b),
        .rdata_a (sq_da),
        .rdata_b (sq_db)
    );

    assign pair.valid = (state_reg == ST_SQ);
    assign pair.first = sq_da;
    assign pair.second = sq_db;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= JMask;
            fill_reg       <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            walk_reg       <= '0;
        end
        else
        begin
            if (place_en)
            begin
                used_reg <= used_base | (LetterOne << place_idx);
                fill_reg <= fill_base + 5'd1;
            end
            else if (fresh)
            begin
                used_reg <= JMask;
                fill_reg <= '0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        unique case (act)
                            ACT_KEY:
                            begin
                                if (fresh)
                                begin
                                    done_reg       <= 1'b0;
                                    pend_valid_reg <= 1'b0;
                                    pend_reg       <= '0;
                                end
                            end
                            ACT_FINISH:
                            begin
                                if (!done_reg)
                                begin
                                    walk_reg  <= '0;
                                    state_reg <= ST_FILL;
                                end
                            end
                            ACT_TEXT:
                            begin
                                if (clean.valid && done_reg)
                                begin
                                    if (!pend_valid_reg)
                                    begin
                                        pend_reg       <= clean.letter;
                                        pend_valid_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_POS;
                                        // doubled letter keeps the second one waiting
                                        if (clean.letter != pend_reg)
                                        begin
                                            pend_valid_reg <= 1'b0;
                                            pend_reg       <= '0;
                                        end
                                    end
                                end
                            end
                            ACT_END:
                            begin
                                if (end_take)
                                begin
                                    state_reg      <= ST_POS;
                                    pend_valid_reg <= 1'b0;
                                    pend_reg       <= '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    walk_reg <= walk_reg + 5'd1;
                    if (walk_reg == 5'(Alpha - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_POS:
                begin
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (pair_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/playfair_cipher_encrypt.sv */
// Playfair encryptor top level: core, two-letter output buffer and checks.
// Key and lone plaintext letters are taken while idle; a finish walks every alphabet
// letter through the square memories in turn before input opens again.
// A completed digraph goes through a position read, a square read and a buffer load;
// its first cipher letter is offered once the buffer load has been registered.
// Input stalls while a digraph waits for the two-entry output buffer to drain.
// Reset clears control state; the square memories hold stale data until rebuilt.
`include "playfair_cipher_encrypt_assert.svh"

module playfair_cipher_encrypt (
    input  logic      clk,
    input  logic      rst_n,
    pf_in_if.sink     plain,
    pf_out_if.source  cipher
);
    import pf_pkg::*;

    pf_pair_t   pair;
    logic       pair_ready;
    logic [1:0] cnt_reg;
    letter_t    first_reg;
    letter_t    second_reg;

    pf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .plain      (plain),
        .pair       (pair),
        .pair_ready (pair_ready)
    );

    assign pair_ready = (cnt_reg == 2'd0);
    assign cipher.valid = (cnt_reg != 2'd0);
    assign cipher.cipher_letter = to_ascii((cnt_reg == 2'd2) ? first_reg : second_reg);
    assign cipher.last_of_run = (cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (pair.valid && pair_ready)
        begin
            cnt_reg <= 2'd2;
        end
        else if (cipher.valid && cipher.ready)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair.valid && pair_ready)
        begin
            first_reg  <= pair.first;
            second_reg <= pair.second;
        end
    end

    `PF_ASSERT_NEVER(a_busy_on_pair, pair.valid && plain.ready, "input open during pair handoff")
    `PF_ASSERT_NEXT(a_load_first, pair.valid && pair_ready, cipher.valid && !cipher.last_of_run, "first letter missing after load")
    `PF_ASSERT_NEXT(a_first_then_last, cipher.valid && cipher.ready && !cipher.last_of_run, cipher.valid && cipher.last_of_run, "second letter missing")
    `PF_ASSERT_NEXT(a_last_drains, cipher.valid && cipher.ready && cipher.last_of_run, !cipher.valid, "buffer not empty after digraph")

endmodule

/* tb/sv/playfair_cipher_encrypt_tb.sv */
// Self-checking testbench for the Playfair encryptor: queued stimulus, inline predictor.
`timescale 1ns / 1ps

module playfair_cipher_encrypt_tb;
    import pf_pkg::*;

    localparam int CycleLimit = 1_000_000;
    localparam int DrainCycles = 40;
    localparam int TargetItems = 1350;

    typedef struct packed {
        action_e    act;
        logic [7:0] ch;
    } plain_item_t;

    typedef struct packed {
        logic [6:0] cipher_letter;
        logic       last_of_run;
    } cipher_item_t;

    logic clk;
    logic rst_n;

    pf_in_if  plain_if();
    pf_out_if cipher_if();

    playfair_cipher_encrypt u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .plain  (plain_if),
        .cipher (cipher_if)
    );

    plain_item_t  plain_queue[$];
    cipher_item_t cipher_expected[$];
    int           fault_count = 0;
    int           cycle_count = 0;
    int           queued_items = 0;

    // predictor state
    letter_t          square[SqCells];
    cell_t            position[Alpha];
    logic [Alpha-1:0] placed;
    int               filled;
    logic             square_done;
    logic             held_valid;
    letter_t          held_letter;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stretches of back-to-back traffic alternate with random gaps
    function automatic int idle_draw();
        return (cycle_count[10] == 1'b1) ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic int letter_of(logic [7:0] b);
        logic [7:0] u;
        int         idx;
        u = (b >= AsciiLowA && b <= AsciiLowZ) ? b - CaseOffset : b;
        if (u < AsciiUpA || u > AsciiUpZ)
        begin
            return -1;
        end
        idx = int'(u - AsciiUpA);
        if (idx == int'(IdxJ))
        begin
            idx = int'(IdxI);
        end
        return idx;
    endfunction

    function automatic void restart_square();
        placed = JMask;
        filled = 0;
        square_done = 1'b0;
        held_valid = 1'b0;
        held_letter = '0;
    endfunction

    function automatic void place_letter(int idx);
        if (filled < SqCells && !placed[idx])
        begin
            square[filled] = letter_t'(idx);
            position[idx] = cell_t'(filled);
            placed[idx] = 1'b1;
            filled++;
        end
    endfunction

    function automatic void expect_digraph(letter_t a, letter_t b);
        int pa;
        int pb;
        int r1;
        int c1;
        int r2;
        int c2;
        int o1;
        int o2;
        pa = int'(position[a]);
        pb = int'(position[b]);
        r1 = pa / SqDim;
        c1 = pa % SqDim;
        r2 = pb / SqDim;
        c2 = pb % SqDim;
        if (r1 == r2)
        begin
            o1 = r1 * SqDim + (c1 + 1) % SqDim;
            o2 = r2 * SqDim + (c2 + 1) % SqDim;
        end
        else if (c1 == c2)
        begin
            o1 = ((r1 + 1) % SqDim) * SqDim + c1;
            o2 = ((r2 + 1) % SqDim) * SqDim + c2;
        end
        else
        begin
            o1 = r1 * SqDim + c2;
            o2 = r2 * SqDim + c1;
        end
        cipher_expected.push_back('{cipher_letter: 7'(AsciiUpA) + 7'(square[o1]),
                                    last_of_run: 1'b0});
        cipher_expected.push_back('{cipher_letter: 7'(AsciiUpA) + 7'(square[o2]),
                                    last_of_run: 1'b1});
    endfunction

    function automatic void encipher_step(action_e act, logic [7:0] ch);
        int l;
        l = letter_of(ch);
        case (act)
            ACT_KEY:
            begin
                if (l >= 0)
                begin
                    if (square_done)
                    begin
                        restart_square();
                    end
                    place_letter(l);
                end
            end
            ACT_FINISH:
            begin
                if (!square_done)
                begin
                    for (int i = 0; i < Alpha; i++)
                    begin
                        place_letter(i);
                    end
                    square_done = 1'b1;
                end
            end
            ACT_TEXT:
            begin
                if (l >= 0 && square_done)
                begin
                    if (!held_valid)
                    begin
                        held_letter = letter_t'(l);
                        held_valid = 1'b1;
                    end
                    else if (letter_t'(l) == held_letter)
                    begin
                        expect_digraph(held_letter, IdxX);
                    end
                    else
                    begin
                        expect_digraph(held_letter, letter_t'(l));
                        held_valid = 1'b0;
                        held_letter = '0;
                    end
                end
            end
            default:
            begin
                if (held_valid && square_done)
                begin
                    expect_digraph(held_letter, IdxX);
                    held_valid = 1'b0;
                    held_letter = '0;
                end
            end
        endcase
    endfunction

    function automatic void queue_item(action_e act, logic [7:0] ch);
        plain_queue.push_back('{act: act, ch: ch});
        queued_items++;
    endfunction

    function automatic logic [7:0] any_letter_byte();
        logic [7:0] b;
        b = AsciiUpA + 8'($urandom_range(0, Alpha - 1));
        if ($urandom_range(0, 1) == 1)
        begin
            b = b + CaseOffset;
        end
        return b;
    endfunction

    // driver: one transfer per queued item, random gap after each
    int plain_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        plain_item_t it;
        if (!rst_n)
        begin
            plain_if.valid <= 1'b0;
            plain_if.action <= ACT_KEY;
            plain_if.char_in <= 8'h00;
            plain_gap = 0;
        end
        else
        begin
            if (plain_if.valid && plain_if.ready)
            begin
                encipher_step(action_e'(plain_if.action), plain_if.char_in);
            end
            if (plain_if.valid && !plain_if.ready)
            begin
                // hold the offered item
            end
            else if (plain_gap > 0)
            begin
                plain_if.valid <= 1'b0;
                plain_gap--;
            end
            else if (plain_queue.size() > 0)
            begin
                it = plain_queue.pop_front();
                plain_if.valid <= 1'b1;
                plain_if.action <= it.act;
                plain_if.char_in <= it.ch;
                plain_gap = idle_draw();
            end
            else
            begin
                plain_if.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each cipher transfer, random stall after each
    int cipher_stall = 0;

    always @(posedge clk or negedge rst_n)
    begin
        cipher_item_t want;
        if (!rst_n)
        begin
            cipher_if.ready <= 1'b0;
            cipher_stall = 0;
        end
        else
        begin
            if (cipher_if.valid && cipher_if.ready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    $error("unexpected cipher transfer: cipher_letter %0d last_of_run %0d",
                           cipher_if.cipher_letter, cipher_if.last_of_run);
                    fault_count++;
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    if (cipher_if.cipher_letter !== want.cipher_letter)
                    begin
                        $error("cipher_letter expected %0d actual %0d",
                               want.cipher_letter, cipher_if.cipher_letter);
                        fault_count++;
                    end
                    if (cipher_if.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run expected %0d actual %0d",
                               want.last_of_run, cipher_if.last_of_run);
                        fault_count++;
                    end
                end
                cipher_stall = idle_draw();
            end
            if (cipher_stall > 0)
            begin
                cipher_if.ready <= 1'b0;
                cipher_stall--;
            end
            else
            begin
                cipher_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int         scen;
        int         n;
        logic [7:0] prev;
        logic [7:0] b;

        rst_n = 1'b0;
        plain_if.valid = 1'b0;
        plain_if.action = ACT_KEY;
        plain_if.char_in = 8'h00;
        cipher_if.ready = 1'b0;
        restart_square();
        for (int i = 0; i < SqCells; i++)
        begin
            square[i] = '0;
        end
        for (int i = 0; i < Alpha; i++)
        begin
            position[i] = '0;
        end

        // directed: key PIZ -> square P I Z A B / C D E F G / H K L M N / O Q R S T / U V W X Y
        queue_item(ACT_TEXT, "A");      // text before finish is dropped
        queue_item(ACT_END, 8'h00);     // nothing pending, square incomplete
        queue_item(ACT_KEY, 8'h00);
        queue_item(ACT_KEY, "p");
        queue_item(ACT_KEY, "J");
        queue_item(ACT_KEY, "i");       // already placed
        queue_item(ACT_KEY, 8'hFF);
        queue_item(ACT_KEY, "Z");
        queue_item(ACT_FINISH, "Q");
        queue_item(ACT_FINISH, 8'hFF);  // second finish does nothing
        queue_item(ACT_END, "E");
        queue_item(ACT_TEXT, "H");
        queue_item(ACT_TEXT, "H");      // doubled letter: H,X and H carries over
        queue_item(ACT_TEXT, "E");      // rectangle
        queue_item(ACT_TEXT, "X");
        queue_item(ACT_TEXT, "x");      // doubled X
        queue_item(ACT_TEXT, "j");
        queue_item(ACT_TEXT, 8'h7B);
        queue_item(ACT_END, 8'h00);     // nothing pending after X,I, so no pad
        queue_item(ACT_TEXT, "A");
        queue_item(ACT_TEXT, "B");      // same row, wraps
        queue_item(ACT_TEXT, "U");
        queue_item(ACT_TEXT, "P");      // same column, wraps
        queue_item(ACT_TEXT, "Q");
        queue_item(ACT_KEY, "M");       // fresh square drops the pending letter
        queue_item(ACT_FINISH, 8'h00);
        queue_item(ACT_TEXT, "Z");
        queue_item(ACT_END, 8'h00);

        while (queued_items < TargetItems)
        begin
            scen = $urandom_range(0, 9);
            if (scen <= 7)
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                begin
                    b = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255))
                                                     : any_letter_byte();
                    queue_item(ACT_KEY, b);
                end
                queue_item(ACT_FINISH, 8'($urandom_range(0, 255)));
                n = $urandom_range(0, 40);
                prev = "A";
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 15))
                        0: b = 8'($urandom_range(0, 255));
                        1, 2: b = ($urandom_range(0, 1) == 1) ? "X" : "x";
                        3, 4, 5, 6: b = prev;
                        default: b = any_letter_byte();
                    endcase
                    queue_item(ACT_TEXT, b);
                    prev = b;
                end
                if ($urandom_range(0, 5) != 0)
                begin
                    queue_item(ACT_END, 8'($urandom_range(0, 255)));
                end
            end
            else if (scen == 8)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    queue_item(action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                queue_item(ACT_KEY, any_letter_byte());
                queue_item(ACT_TEXT, any_letter_byte());
                queue_item(ACT_END, 8'($urandom_range(0, 255)));
                queue_item(ACT_FINISH, 8'($urandom_range(0, 255)));
                queue_item(ACT_FINISH, 8'($urandom_range(0, 255)));
                queue_item(ACT_TEXT, any_letter_byte());
                queue_item(ACT_KEY, any_letter_byte());
                queue_item(ACT_TEXT, any_letter_byte());
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (plain_queue.size() != 0 || plain_if.valid || cipher_expected.size() != 0);
        repeat (DrainCycles) @(posedge clk);

        if (cipher_expected.size() != 0)
        begin
            $error("%0d cipher letters never arrived", cipher_expected.size());
            fault_count++;
        end
        if (fault_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
